[rtl/ocp_pkg.sv]
// Shared types, constants and codes for the overcurrent trip block.
package ocp_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int CHAN_W        = 4;
    localparam int CUR_W         = 20;
    localparam int THR_W         = 20;
    localparam int SAMPLE_W      = 18;
    localparam int CHIN_W        = 8;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 20;

    localparam logic [CUR_W-1:0] MAX_SAMPLE_MA = CUR_W'(200000);

    localparam logic [CHAN_W-1:0] CHAN_ALL = CHAN_W'(NUM_CHANNELS);
    localparam logic [CHIN_W-1:0] CHAN_LIMIT = CHIN_W'(NUM_CHANNELS);

    localparam logic [1:0] LVL_NORMAL   = 2'd0;
    localparam logic [1:0] LVL_WARNING  = 2'd1;
    localparam logic [1:0] LVL_CRITICAL = 2'd2;
    localparam logic [1:0] LVL_LOCKOUT  = 2'd3;

    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_CHAN_ON = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY = 2'd3;

    localparam logic [THR_W-1:0] WARNING_RESET  = THR_W'(999000);
    localparam logic [THR_W-1:0] CRITICAL_RESET = THR_W'(999750);
    localparam logic [THR_W-1:0] RECOVERY_RESET = THR_W'(998000);

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [CUR_W-1:0] current_ma;
        logic [CHIN_W-1:0]       channel;
        logic [TIME_W-1:0]       time_ms;
    } item_t;

    typedef struct packed {
        logic             enabled;
        logic [THR_W-1:0] warning_ma;
        logic [THR_W-1:0] critical_ma;
        logic [THR_W-1:0] recovery_ma;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          prot_level;
        logic                switching_ok;
        logic                turn_on_ok;
        logic                trip_now;
        logic [CHAN_W-1:0]   trip_target;
        logic                lockout_cleared;
        logic [COUNT_W-1:0]  trip_total;
        logic [TIME_W-1:0]   last_trip_ms;
        logic [SAMPLE_W-1:0] latest_ma;
    } result_t;

endpackage

[rtl/overcurrent_trip_state_machine.sv]
// Top level of the tiered overcurrent trip block: configuration, stages and result register.
//
//   Channel   Handshake                     Payload
//   input     item_valid / item_ready       mode, current_ma, channel, time_ms
//   result    result_valid / result_ready   prot_level ... latest_ma
//   config    cfg_we (no wait)              cfg_index, cfg_data
//
// A transaction is held in the input register, where the core evaluates it
// against the stored protection state, and then sits in the result register.
// Result valid is set as the transaction moves from the input register into the result
// register; one transaction per cycle is sustained while result_ready stays high.
// When the result register is stalled, the input register still takes one more
// transaction; after that item_ready follows result_ready.
// Reset is asynchronous and active low; it restores default thresholds, disables
// the block, clears the level to normal and allows switching.
module overcurrent_trip_state_machine
    import ocp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [1:0]              mode,
    input  logic signed [CUR_W-1:0] current_ma,
    input  logic [CHIN_W-1:0]       channel,
    input  logic [TIME_W-1:0]       time_ms,

    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [1:0]              prot_level,
    output logic                    switching_ok,
    output logic                    turn_on_ok,
    output logic                    trip_now,
    output logic [CHAN_W-1:0]       trip_target,
    output logic                    lockout_cleared,
    output logic [COUNT_W-1:0]      trip_total,
    output logic [TIME_W-1:0]       last_trip_ms,
    output logic [SAMPLE_W-1:0]     latest_ma
);

    cfg_t    cfg_reg;
    item_t   item_in;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    logic    out_valid_reg;
    result_t core_res;
    result_t out_reg;

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled     <= 1'b0;
            cfg_reg.warning_ma  <= WARNING_RESET;
            cfg_reg.critical_ma <= CRITICAL_RESET;
            cfg_reg.recovery_ma <= RECOVERY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLED:  cfg_reg.enabled     <= cfg_data[0];
                REG_WARNING:  cfg_reg.warning_ma  <= cfg_data[THR_W-1:0];
                REG_CRITICAL: cfg_reg.critical_ma <= cfg_data[THR_W-1:0];
                REG_RECOVERY: cfg_reg.recovery_ma <= cfg_data[THR_W-1:0];
                default:      cfg_reg.enabled     <= cfg_reg.enabled;
            endcase
        end
    end

    assign item_in.mode       = mode;
    assign item_in.current_ma = current_ma;
    assign item_in.channel    = channel;
    assign item_in.time_ms    = time_ms;

    // The held transaction moves into the result register whenever that register is
    // empty or its content is being taken this cycle.
    assign advance = held_valid && (!out_valid_reg || result_ready);

    ocp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_in    (item_in),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ocp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (held_item),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    assign result_valid    = out_valid_reg;
    assign prot_level      = out_reg.prot_level;
    assign switching_ok    = out_reg.switching_ok;
    assign turn_on_ok      = out_reg.turn_on_ok;
    assign trip_now        = out_reg.trip_now;
    assign trip_target     = out_reg.trip_target;
    assign lockout_cleared = out_reg.lockout_cleared;
    assign trip_total      = out_reg.trip_total;
    assign last_trip_ms    = out_reg.last_trip_ms;
    assign latest_ma       = out_reg.latest_ma;

endmodule

[rtl/ocp_in_reg.sv]
// Input register stage that captures one transaction and holds it for the core.
module ocp_in_reg
    import ocp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item_in,
    input  logic  advance,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage can take a new transaction when empty or when it empties now.
    assign item_ready = !valid_reg || advance;
    assign valid_next = item_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[rtl/ocp_core.sv]
// Protection level state, trip bookkeeping and the per-transaction result logic.
module ocp_core
    import ocp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [1:0]          level_reg,     level_next;
    logic                sw_en_reg,     sw_en_next;
    logic [CHAN_W-1:0]   recent_ch_reg, recent_ch_next;
    logic [COUNT_W-1:0]  trip_cnt_reg,  trip_cnt_next;
    logic [TIME_W-1:0]   trip_time_reg, trip_time_next;
    logic [SAMPLE_W-1:0] sample_reg,    sample_next;

    logic                in_range;
    logic [THR_W-1:0]    cur_u;
    logic [1:0]          sample_level;
    logic                trip;
    logic                cleared;
    logic                do_sample;

    assign cur_u     = THR_W'($unsigned(item.current_ma));
    assign in_range  = !item.current_ma[CUR_W-1] && (item.current_ma <= MAX_SAMPLE_MA);
    assign do_sample = (item.mode == MODE_SAMPLE) && cfg.enabled && in_range;

    // Level transition for an accepted sample.
    always_comb
    begin
        sample_level = level_reg;
        case (level_reg)
            LVL_NORMAL:
            begin
                if (cur_u >= cfg.critical_ma)
                    sample_level = LVL_CRITICAL;
                else if (cur_u >= cfg.warning_ma)
                    sample_level = LVL_WARNING;
            end
            LVL_WARNING:
            begin
                if (cur_u >= cfg.critical_ma)
                    sample_level = LVL_CRITICAL;
                else if (cur_u < cfg.warning_ma)
                    sample_level = LVL_NORMAL;
            end
            LVL_CRITICAL:
            begin
                sample_level = (cur_u >= cfg.critical_ma) ? LVL_LOCKOUT : LVL_NORMAL;
            end
            default:
            begin
                if (cur_u < cfg.recovery_ma)
                    sample_level = LVL_NORMAL;
            end
        endcase
    end

    always_comb
    begin
        level_next     = level_reg;
        sw_en_next     = sw_en_reg;
        recent_ch_next = recent_ch_reg;
        trip_cnt_next  = trip_cnt_reg;
        trip_time_next = trip_time_reg;
        sample_next    = sample_reg;
        trip           = 1'b0;
        cleared        = 1'b0;
        if (item.mode == MODE_SAMPLE)
        begin
            if (do_sample)
            begin
                sample_next = cur_u[SAMPLE_W-1:0];
                level_next  = sample_level;
                if (sample_level != level_reg)
                begin
                    if (sample_level == LVL_LOCKOUT)
                    begin
                        sw_en_next     = 1'b0;
                        trip           = 1'b1;
                        trip_cnt_next  = trip_cnt_reg + COUNT_W'(1);
                        trip_time_next = item.time_ms;
                    end
                    else if (sample_level == LVL_NORMAL && level_reg == LVL_LOCKOUT)
                    begin
                        sw_en_next = 1'b1;
                    end
                end
            end
        end
        else if (item.mode == MODE_CHAN_ON)
        begin
            if (item.channel < CHAN_LIMIT)
                recent_ch_next = item.channel[CHAN_W-1:0];
        end
        else if (item.mode == MODE_CLEAR)
        begin
            if (level_reg == LVL_LOCKOUT)
            begin
                level_next = LVL_NORMAL;
                sw_en_next = 1'b1;
                cleared    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LVL_NORMAL;
            sw_en_reg     <= 1'b1;
            recent_ch_reg <= CHAN_ALL;
            trip_cnt_reg  <= '0;
            trip_time_reg <= '0;
            sample_reg    <= '0;
        end
        else if (fire)
        begin
            level_reg     <= level_next;
            sw_en_reg     <= sw_en_next;
            recent_ch_reg <= recent_ch_next;
            trip_cnt_reg  <= trip_cnt_next;
            trip_time_reg <= trip_time_next;
            sample_reg    <= sample_next;
        end
    end

    // The stored channel is either a valid channel or the all-channels code left by
    // reset, so it is the trip target as is.
    always_comb
    begin
        res.prot_level      = (item.mode == MODE_SAMPLE && !cfg.enabled) ? LVL_NORMAL
                                                                         : level_next;
        res.switching_ok    = cfg.enabled ? sw_en_next : 1'b1;
        res.turn_on_ok      = cfg.enabled ? (sw_en_next && level_next == LVL_NORMAL) : 1'b1;
        res.trip_now        = trip;
        res.trip_target     = trip ? recent_ch_reg : '0;
        res.lockout_cleared = cleared;
        res.trip_total      = trip_cnt_next;
        res.last_trip_ms    = trip_time_next;
        res.latest_ma       = sample_next;
    end

endmodule

[rtl/ocp_checker.sv]
// Port-level checks on the overcurrent trip block and the bind that attaches them.
module ocp_checker
    import ocp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input logic [1:0]          prot_level,
    input logic                switching_ok,
    input logic                turn_on_ok,
    input logic                trip_now,
    input logic [CHAN_W-1:0]   trip_target,
    input logic                lockout_cleared,
    input logic [COUNT_W-1:0]  trip_total
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(prot_level)
            && $stable(trip_now) && $stable(trip_total))
        else $error("stalled result changed");

    // A trip always reports lockout with switching blocked and a valid target.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && trip_now |-> prot_level == LVL_LOCKOUT && !switching_ok
            && !turn_on_ok && trip_target <= CHAN_ALL)
        else $error("trip result inconsistent");

    // Without a trip the target field is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !trip_now |-> trip_target == '0)
        else $error("trip target set without trip");

    // A cleared lockout leaves the level normal with switching allowed.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && lockout_cleared |-> prot_level == LVL_NORMAL && switching_ok
            && turn_on_ok && !trip_now)
        else $error("lockout clear result inconsistent");

endmodule

bind overcurrent_trip_state_machine ocp_checker u_ocp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .prot_level      (prot_level),
    .switching_ok    (switching_ok),
    .turn_on_ok      (turn_on_ok),
    .trip_now        (trip_now),
    .trip_target     (trip_target),
    .lockout_cleared (lockout_cleared),
    .trip_total      (trip_total)
);
